FILE: rtl/itp_pkg.sv
// itp_pkg: shared types, codes and helper functions of the infix to postfix converter
// no dependencies; imported by itp_datapath, itp_controller and the top level
package itp_pkg;

    // operator stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // operator and function codes as they leave the block
    localparam logic [3:0] OP_PLUS   = 4'd0;
    localparam logic [3:0] OP_MINUS  = 4'd1;
    localparam logic [3:0] OP_TIMES  = 4'd2;
    localparam logic [3:0] OP_POWER  = 4'd3;
    localparam logic [3:0] OP_SIN    = 4'd4;
    localparam logic [3:0] OP_COS    = 4'd5;
    localparam logic [3:0] OP_TAN    = 4'd6;
    localparam logic [3:0] OP_SEC    = 4'd7;
    localparam logic [3:0] OP_CSC    = 4'd8;
    localparam logic [3:0] OP_COT    = 4'd9;
    localparam logic [3:0] OPEN_CODE = 4'd10;
    // no function name found
    localparam logic [3:0] FUNC_NONE = 4'd0;

    // token kinds
    localparam logic [1:0] KIND_OPERAND = 2'd0;
    localparam logic [1:0] KIND_OP      = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // sticky error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_CLOSE    = 2'd2;
    localparam logic [1:0] ERR_OPEN     = 2'd3;

    // ascii characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_POWER = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    // character classes
    typedef logic [2:0] cls_t;
    localparam cls_t CLS_OPERAND = 3'd0;
    localparam cls_t CLS_PLUS    = 3'd1;
    localparam cls_t CLS_MINUS   = 3'd2;
    localparam cls_t CLS_TIMES   = 3'd3;
    localparam cls_t CLS_POWER   = 3'd4;
    localparam cls_t CLS_OPEN    = 3'd5;
    localparam cls_t CLS_CLOSE   = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic load;          // take the accepted character into the lookahead
        logic push;          // push onto the operator stack
        logic push_func;     // pushed code is the function code, else the character's code
        logic pop;           // drop the top of stack
        logic emit_op;       // send the top of stack as an operator token
        logic emit_operand;  // send the oldest lookahead character as an operand
        logic emit_end;      // send the end marker
        logic consume_one;   // drop the oldest lookahead character
        logic consume_all;   // drop all lookahead characters
        logic inside_clr;    // leave operand token
        logic err_close;     // unmatched close
        logic err_open;      // unmatched open
        logic clear_all;     // clear lookahead, stack, error and operand flag as at reset
    } itp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] q_count;
        logic       last;
        cls_t       cls;
        logic       func_hit;
        logic       stack_empty;
        logic       top_open;
        logic       pop_ok;
        logic       out_free;
    } itp_status_t;

    function automatic cls_t char_class(input logic [7:0] c);
        cls_t r;
        case (c)
            CH_PLUS:  r = CLS_PLUS;
            CH_MINUS: r = CLS_MINUS;
            CH_TIMES: r = CLS_TIMES;
            CH_POWER: r = CLS_POWER;
            CH_OPEN:  r = CLS_OPEN;
            CH_CLOSE: r = CLS_CLOSE;
            default:  r = CLS_OPERAND;
        endcase
        return r;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return char_class(c) != CLS_OPERAND;
    endfunction

    function automatic logic [3:0] func_code(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        logic [3:0] r;
        r = FUNC_NONE;
        if (a == CH_S && b == CH_I && c == CH_N) r = OP_SIN;
        if (a == CH_C && b == CH_O && c == CH_S) r = OP_COS;
        if (a == CH_T && b == CH_A && c == CH_N) r = OP_TAN;
        if (a == CH_S && b == CH_E && c == CH_C) r = OP_SEC;
        if (a == CH_C && b == CH_S && c == CH_C) r = OP_CSC;
        if (a == CH_C && b == CH_O && c == CH_T) r = OP_COT;
        return r;
    endfunction

endpackage

FILE: rtl/itp_datapath.sv
// itp_datapath: lookahead registers, operator stack memory, sticky error and result register
// depends on itp_pkg; driven by itp_controller through itp_cmd_t
module itp_datapath import itp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    symbol,
    input  logic          last,
    input  itp_cmd_t      cmd,
    output itp_status_t   st,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    token_kind,
    output logic [7:0]    operand_char,
    output logic [3:0]    op_code,
    output logic          token_end,
    output logic [1:0]    error,
    output logic          done_res
);

    // lookahead
    logic [7:0] q0_reg, q0_next;
    logic [7:0] q1_reg, q1_next;
    logic [7:0] q2_reg, q2_next;
    logic [1:0] qcnt_reg, qcnt_next;
    logic       last_reg, last_next;
    logic       inside_reg, inside_next;
    logic [1:0] err_reg, err_next;

    // stack
    logic [3:0]        stack_mem [STACK_DEPTH];
    logic [3:0]        top_reg;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0]  sp_dec;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              full;
    logic              do_write;
    logic [3:0]        push_code;
    logic [3:0]        char_code;
    logic [3:0]        fc;
    cls_t              cls;
    logic              op_end;
    logic              pop_ok;

    // result register
    logic       ov_reg, ov_next;
    logic [1:0] kind_reg;
    logic [7:0] ch_reg;
    logic [3:0] opc_reg;
    logic       tend_reg;
    logic [1:0] oerr_reg;
    logic       done_reg;
    logic       out_free;
    logic       emit_any;

    assign cls      = char_class(q0_reg);
    assign fc       = func_code(q0_reg, q1_reg, q2_reg);
    assign op_end   = (qcnt_reg >= 2'd2) ? is_delim(q1_reg) : 1'b1;
    assign full     = (sp_reg == CNT_W'(STACK_DEPTH));
    assign do_write = cmd.push && !full;
    assign wr_addr  = sp_reg[ADDR_W-1:0];
    assign out_free = !ov_reg || out_ready;
    assign emit_any = cmd.emit_op || cmd.emit_operand || cmd.emit_end;

    always_comb
    begin
        case (cls)
            CLS_PLUS:  char_code = OP_PLUS;
            CLS_MINUS: char_code = OP_MINUS;
            CLS_TIMES: char_code = OP_TIMES;
            CLS_POWER: char_code = OP_POWER;
            default:   char_code = OPEN_CODE;
        endcase
    end

    assign push_code = cmd.push_func ? fc : char_code;

    // pop rule of the character at the head of the lookahead
    always_comb
    begin
        case (cls)
            CLS_PLUS, CLS_MINUS, CLS_CLOSE: pop_ok = (top_reg != OPEN_CODE);
            CLS_TIMES: pop_ok = (top_reg >= OP_TIMES) && (top_reg <= OP_COT);
            CLS_POWER: pop_ok = (top_reg >= OP_POWER) && (top_reg <= OP_COT);
            default:   pop_ok = 1'b0;
        endcase
        pop_ok = pop_ok && (sp_reg != '0);
    end

    always_comb
    begin
        q0_next     = q0_reg;
        q1_next     = q1_reg;
        q2_next     = q2_reg;
        qcnt_next   = qcnt_reg;
        last_next   = last_reg;
        inside_next = inside_reg;
        err_next    = err_reg;
        sp_next     = sp_reg;

        if (cmd.load)
        begin
            case (qcnt_reg)
                2'd0:    q0_next = symbol;
                2'd1:    q1_next = symbol;
                default: q2_next = symbol;
            endcase
            qcnt_next = qcnt_reg + 2'd1;
            last_next = last;
        end
        if (cmd.consume_one)
        begin
            q0_next   = q1_reg;
            q1_next   = q2_reg;
            qcnt_next = qcnt_reg - 2'd1;
        end
        if (cmd.consume_all)
            qcnt_next = '0;

        if (cmd.emit_operand)
            inside_next = !op_end;
        if (cmd.inside_clr)
            inside_next = 1'b0;

        if (do_write)
            sp_next = sp_reg + CNT_W'(1);
        else if (cmd.pop)
            sp_next = sp_reg - CNT_W'(1);

        // first error wins
        if (err_reg == ERR_NONE)
        begin
            if (cmd.push && full)
                err_next = ERR_OVERFLOW;
            else if (cmd.err_close)
                err_next = ERR_CLOSE;
            else if (cmd.err_open)
                err_next = ERR_OPEN;
        end

        if (cmd.clear_all)
        begin
            qcnt_next   = '0;
            last_next   = 1'b0;
            inside_next = 1'b0;
            err_next    = ERR_NONE;
            sp_next     = '0;
        end
    end

    assign sp_dec  = sp_next - CNT_W'(1);
    assign rd_addr = sp_dec[ADDR_W-1:0];

    // stack memory, top of stack kept in a registered read
    always_ff @(posedge clk)
    begin
        if (do_write)
            stack_mem[wr_addr] <= push_code;
        top_reg <= do_write ? push_code : stack_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
        q2_reg <= q2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcnt_reg   <= '0;
            last_reg   <= 1'b0;
            inside_reg <= 1'b0;
            err_reg    <= ERR_NONE;
            sp_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            qcnt_reg   <= qcnt_next;
            last_reg   <= last_next;
            inside_reg <= inside_next;
            err_reg    <= err_next;
            sp_reg     <= sp_next;
            ov_reg     <= ov_next;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (emit_any)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            oerr_reg <= err_reg;
            done_reg <= cmd.emit_end;
            if (cmd.emit_operand)
            begin
                kind_reg <= KIND_OPERAND;
                ch_reg   <= q0_reg;
                opc_reg  <= '0;
                tend_reg <= op_end;
            end
            else if (cmd.emit_op)
            begin
                kind_reg <= KIND_OP;
                ch_reg   <= '0;
                opc_reg  <= top_reg;
                tend_reg <= 1'b0;
            end
            else
            begin
                kind_reg <= KIND_END;
                ch_reg   <= '0;
                opc_reg  <= '0;
                tend_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign token_kind   = kind_reg;
    assign operand_char = ch_reg;
    assign op_code      = opc_reg;
    assign token_end    = tend_reg;
    assign error        = oerr_reg;
    assign done_res     = done_reg;

    assign st.q_count     = qcnt_reg;
    assign st.last        = last_reg;
    assign st.cls         = cls;
    assign st.func_hit    = (qcnt_reg == 2'd3) && !inside_reg && (fc != FUNC_NONE);
    assign st.stack_empty = (sp_reg == '0);
    assign st.top_open    = (top_reg == OPEN_CODE);
    assign st.pop_ok      = pop_ok;
    assign st.out_free    = out_free;

endmodule

FILE: rtl/itp_controller.sv
// itp_controller: sequencing state machine of the converter
// depends on itp_pkg; commands itp_datapath from its status
module itp_controller import itp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  itp_status_t st,
    output itp_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_CHAR   = 2'd2;
    localparam logic [1:0] S_DRAIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!st.last && st.q_count != 2'd3)
                    state_next = S_IDLE;
                else if (st.q_count == 2'd0)
                    state_next = S_DRAIN;
                else if (st.func_hit)
                begin
                    cmd.push        = 1'b1;
                    cmd.push_func   = 1'b1;
                    cmd.consume_all = 1'b1;
                    cmd.inside_clr  = 1'b1;
                end
                else
                    state_next = S_CHAR;
            end
            S_CHAR:
            begin
                case (st.cls)
                    CLS_OPERAND:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit_operand = 1'b1;
                            cmd.consume_one  = 1'b1;
                            state_next       = S_DECIDE;
                        end
                    end
                    CLS_OPEN:
                    begin
                        cmd.push        = 1'b1;
                        cmd.inside_clr  = 1'b1;
                        cmd.consume_one = 1'b1;
                        state_next      = S_DECIDE;
                    end
                    CLS_CLOSE:
                    begin
                        if (st.pop_ok)
                        begin
                            if (st.out_free)
                            begin
                                cmd.pop     = 1'b1;
                                cmd.emit_op = 1'b1;
                            end
                        end
                        else
                        begin
                            if (st.stack_empty)
                                cmd.err_close = 1'b1;
                            else
                                cmd.pop = 1'b1;
                            cmd.inside_clr  = 1'b1;
                            cmd.consume_one = 1'b1;
                            state_next      = S_DECIDE;
                        end
                    end
                    default:
                    begin
                        if (st.pop_ok)
                        begin
                            if (st.out_free)
                            begin
                                cmd.pop     = 1'b1;
                                cmd.emit_op = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.push        = 1'b1;
                            cmd.inside_clr  = 1'b1;
                            cmd.consume_one = 1'b1;
                            state_next      = S_DECIDE;
                        end
                    end
                endcase
            end
            S_DRAIN:
            begin
                if (!st.stack_empty)
                begin
                    if (st.top_open)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.err_open = 1'b1;
                    end
                    else if (st.out_free)
                    begin
                        cmd.pop     = 1'b1;
                        cmd.emit_op = 1'b1;
                    end
                end
                else if (st.out_free)
                begin
                    cmd.emit_end  = 1'b1;
                    cmd.clear_all = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/infix_to_postfix_converter_core.sv
// infix_to_postfix_converter_core: top level of the shunting-yard infix to postfix converter
// depends on itp_pkg, itp_controller and itp_datapath
//
// takes one ascii character per request and sends postfix tokens one per request; operand
// characters pass through with a token-end mark, operators and the six trig names go through
// an operator stack of STACK_DEPTH entries held in a memory with a registered top of stack.
// one character is handled at a time. a character that only fills the lookahead is accepted
// and decided; a character that is worked off is accepted, decided, handled and decided again,
// with a further handle step for every operator popped; a recognized function name is
// accepted, decided with a push and decided again. the final character works off every held
// character the same way (decide and handle, or one decide for a function name), then takes
// a decide step, a drain step for each remaining stack entry and one for the end marker. the
// pace is set by the single stack port, which moves at most one entry per cycle, and by the
// result register, which holds one token until the sink takes it. a result may wait in the
// result register while the block keeps working; the block stalls only when it has the next
// token ready. errors are sticky for the expression and clear with the end marker.
// no clearing pass is needed after reset.
module infix_to_postfix_converter_core import itp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] token_kind,
    output logic [7:0] operand_char,
    output logic [3:0] op_code,
    output logic       token_end,
    output logic [1:0] error,
    output logic       done_res
);

    itp_cmd_t    cmd;
    itp_status_t st;

    // sequencer: accept, lookahead decisions, pop loops and the final drain
    itp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // lookahead, stack, sticky error and result register
    itp_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol       (symbol),
        .last         (last),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .operand_char (operand_char),
        .op_code      (op_code),
        .token_end    (token_end),
        .error        (error),
        .done_res     (done_res)
    );

`ifndef ASSERT_OFF
    // a token is only produced when the result register can take it
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_op || cmd.emit_operand || cmd.emit_end) |-> st.out_free)
        else $error("token produced while result register is full");

    // at most one stack or lookahead-load action per cycle
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push, cmd.pop, cmd.load}))
        else $error("conflicting stack commands");

    // lookahead never takes a fourth character
    a_lookahead_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (st.q_count != 2'd3))
        else $error("lookahead overrun");

    // the end marker is the only result flagged as final
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (token_kind == KIND_END))
        else $error("final flag on a non end token");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for infix_to_postfix_converter_core, one character per request
// depends on itp_pkg and the converter rtl; a built-in shunting-yard predictor checks every token

module testbench;
    import itp_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_STEP_TOKENS = 20;     // tokens one character can release at most
    localparam int RANDOM_CHARS    = 385;
    localparam int DRAIN_AT        = 300;    // first expression starting here waits for all tokens
    localparam int HOLD_AT         = 340;    // sink holds off once this many characters went in
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 40;
    localparam int MAX_PRINTS      = 60;
    localparam logic [3:0] NO_OP   = 4'd0;
    localparam logic [7:0] NO_CHAR = 8'h00;

    // one character request as queued for the driver
    typedef struct {
        logic [7:0] sym;
        logic       fin;
        bit         drain;
    } char_req_t;

    // one postfix token as expected at the output
    typedef struct {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [3:0] op;
        logic       tend;
        logic [1:0] err;
        logic       done;
    } token_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] symbol       = 8'h00;
    logic       last         = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [1:0] token_kind;
    logic [7:0] operand_char;
    logic [3:0] op_code;
    logic       token_end;
    logic [1:0] error;
    logic       done_res;

    char_req_t   char_q[$];
    logic [7:0]  expr_buf[$];
    token_t      pending_tokens[$];
    string       func_names[6] = '{"sin", "cos", "tan", "sec", "csc", "cot"};

    int          total_items   = 0;
    int          sent_count    = 0;
    int          token_count   = 0;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;
    bit          drain_marked  = 1'b0;

    // predictor state: operator stack, held lookahead characters, token flag, sticky error
    logic [3:0]  op_stack[STACK_DEPTH];
    int          op_depth      = 0;
    logic [7:0]  held_chars[2];
    int          held_count    = 0;
    bit          in_token      = 1'b0;
    logic [1:0]  expr_error    = ERR_NONE;
    int          step_tokens   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    infix_to_postfix_converter_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .operand_char (operand_char),
        .op_code      (op_code),
        .token_end    (token_end),
        .error        (error),
        .done_res     (done_res)
    );

    // ------------------------------------------------------------------
    // shunting-yard predictor
    // ------------------------------------------------------------------

    // trig name at the head of a three-character window, or FUNC_NONE
    function automatic logic [3:0] trig_name(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        case ({a, b, c})
            "sin":   return OP_SIN;
            "cos":   return OP_COS;
            "tan":   return OP_TAN;
            "sec":   return OP_SEC;
            "csc":   return OP_CSC;
            "cot":   return OP_COT;
            default: return FUNC_NONE;
        endcase
    endfunction

    function automatic bit ends_operand(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_TIMES || c == CH_POWER ||
               c == CH_OPEN || c == CH_CLOSE;
    endfunction

    task automatic queue_token(input logic [1:0] kind, input logic [7:0] ch,
                               input logic [3:0] op, input logic tend);
        token_t t;
        if (step_tokens >= MAX_STEP_TOKENS)
            return;
        t.kind = kind;
        t.ch   = ch;
        t.op   = op;
        t.tend = tend;
        t.err  = expr_error;
        t.done = 1'b0;
        pending_tokens.insert(pending_tokens.size(), t);
        step_tokens++;
    endtask

    // only the first error of an expression sticks
    task automatic flag_error(input logic [1:0] e);
        if (expr_error == ERR_NONE)
            expr_error = e;
    endtask

    task automatic push_code(input logic [3:0] code);
        if (op_depth >= STACK_DEPTH)
        begin
            flag_error(ERR_OVERFLOW);
            return;
        end
        op_stack[op_depth] = code;
        op_depth++;
    endtask

    task automatic pop_to_output();
        op_depth--;
        queue_token(KIND_OP, NO_CHAR, op_stack[op_depth], 1'b0);
    endtask

    task automatic take_char(input logic [7:0] c, input logic [7:0] nxt, input bit has_nxt);
        bit tend;
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            while (op_depth > 0 && op_stack[op_depth-1] != OPEN_CODE)
                pop_to_output();
            push_code(c == CH_PLUS ? OP_PLUS : OP_MINUS);
        end
        else if (c == CH_TIMES)
        begin
            while (op_depth > 0 && op_stack[op_depth-1] >= OP_TIMES &&
                   op_stack[op_depth-1] <= OP_COT)
                pop_to_output();
            push_code(OP_TIMES);
        end
        else if (c == CH_POWER)
        begin
            while (op_depth > 0 && op_stack[op_depth-1] >= OP_POWER &&
                   op_stack[op_depth-1] <= OP_COT)
                pop_to_output();
            push_code(OP_POWER);
        end
        else if (c == CH_OPEN)
        begin
            push_code(OPEN_CODE);
        end
        else if (c == CH_CLOSE)
        begin
            while (op_depth > 0 && op_stack[op_depth-1] != OPEN_CODE)
                pop_to_output();
            if (op_depth == 0)
                flag_error(ERR_CLOSE);
            else
                op_depth--;
        end
        else
        begin
            tend = has_nxt ? ends_operand(nxt) : 1'b1;
            queue_token(KIND_OPERAND, c, NO_OP, tend);
            in_token = !tend;
            return;
        end
        in_token = 1'b0;
    endtask

    // tokens released by one accepted character
    task automatic predict_symbol(input logic [7:0] sym, input logic is_last);
        logic [7:0] win[3];
        logic [3:0] f;
        int         n;
        int         i;
        bit         hn;
        token_t     fin_tok;
        step_tokens = 0;
        for (i = 0; i < held_count; i++)
            win[i] = held_chars[i];
        win[held_count] = sym;
        n = held_count + 1;
        if (!is_last)
        begin
            if (n < 3)
            begin
                // still filling the lookahead
                held_chars[n-1] = sym;
                held_count      = n;
            end
            else
            begin
                f = in_token ? FUNC_NONE : trig_name(win[0], win[1], win[2]);
                if (f != FUNC_NONE)
                begin
                    push_code(f);
                    in_token   = 1'b0;
                    held_count = 0;
                end
                else
                begin
                    take_char(win[0], win[1], 1'b1);
                    held_chars[0] = win[1];
                    held_chars[1] = win[2];
                    held_count    = 2;
                end
            end
        end
        else
        begin
            // final character: work off the window, then empty the stack
            i = 0;
            while (i < n)
            begin
                f = (n - i >= 3 && !in_token) ? trig_name(win[i], win[i+1], win[i+2])
                                              : FUNC_NONE;
                if (f != FUNC_NONE)
                begin
                    push_code(f);
                    in_token = 1'b0;
                    i += 3;
                end
                else
                begin
                    hn = (i + 1) < n;
                    take_char(win[i], hn ? win[i+1] : NO_CHAR, hn);
                    i++;
                end
            end
            while (op_depth > 0)
            begin
                if (op_stack[op_depth-1] == OPEN_CODE)
                begin
                    op_depth--;
                    flag_error(ERR_OPEN);
                end
                else
                begin
                    pop_to_output();
                end
            end
            // the end marker always gets a slot, taking the last one if need be
            if (step_tokens >= MAX_STEP_TOKENS)
                void'(pending_tokens.pop_back());
            fin_tok.kind = KIND_END;
            fin_tok.ch   = NO_CHAR;
            fin_tok.op   = NO_OP;
            fin_tok.tend = 1'b0;
            fin_tok.err  = expr_error;
            fin_tok.done = 1'b1;
            pending_tokens.insert(pending_tokens.size(), fin_tok);
            op_depth   = 0;
            held_count = 0;
            in_token   = 1'b0;
            expr_error = ERR_NONE;
        end
    endtask

    // ------------------------------------------------------------------
    // expression builders, all write into expr_buf
    // ------------------------------------------------------------------

    task automatic add_char(input logic [7:0] c);
        expr_buf.insert(expr_buf.size(), c);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic add_func_name();
        add_text(func_names[$urandom_range(0, 5)]);
    endtask

    task automatic add_operand();
        int len;
        len = $urandom_range(1, 3);
        repeat (len)
        begin
            if ($urandom_range(0, 3) == 0)
                add_char(8'h30 + 8'($urandom_range(0, 9)));   // digit
            else
                add_char(CH_A + 8'($urandom_range(0, 25)));   // lower-case letter
        end
    endtask

    task automatic add_operator();
        case ($urandom_range(0, 3))
            0:       add_char(CH_PLUS);
            1:       add_char(CH_MINUS);
            2:       add_char(CH_TIMES);
            default: add_char(CH_POWER);
        endcase
    endtask

    // well-formed infix expression with nesting, trig names and multi-character operands
    task automatic build_formula();
        int terms;
        int nest;
        int t;
        terms = $urandom_range(1, 5);
        nest  = 0;
        for (t = 0; t < terms; t++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    if (nest < 4)
                    begin
                        add_char(CH_OPEN);
                        nest++;
                    end
                end
                1:
                begin
                    add_func_name();
                    if (nest < 4)
                    begin
                        add_char(CH_OPEN);
                        nest++;
                    end
                end
                2:       add_func_name();
                default: ;
            endcase
            add_operand();
            while (nest > 0 && $urandom_range(0, 2) == 0)
            begin
                add_char(CH_CLOSE);
                nest--;
            end
            if (t < terms - 1)
                add_operator();
        end
        while (nest > 0)
        begin
            add_char(CH_CLOSE);
            nest--;
        end
    endtask

    // more pushes than the stack holds, so the overflow error fires
    task automatic build_overflow();
        repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4))
        begin
            if ($urandom_range(0, 1) == 0)
                add_char(CH_OPEN);
            else
                add_func_name();
        end
        add_operand();
        repeat ($urandom_range(0, 3))
            add_char(CH_CLOSE);
    endtask

    task automatic build_broken();
        case ($urandom_range(0, 3))
            0: build_overflow();
            1:
            begin
                build_formula();
                expr_buf.insert($urandom_range(0, expr_buf.size()), CH_CLOSE);
            end
            2:
            begin
                build_formula();
                expr_buf.insert($urandom_range(0, expr_buf.size()), CH_OPEN);
            end
            default:
            begin
                build_formula();
                if (expr_buf.size() > 1)
                    expr_buf.delete($urandom_range(0, expr_buf.size() - 1));
            end
        endcase
    endtask

    // arbitrary bytes mixed with delimiters
    task automatic build_noise();
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 5))
                0:       add_operator();
                1:       add_char(CH_OPEN);
                2:       add_char(CH_CLOSE);
                default: add_char(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // move the built expression into the request queue, last character marked
    task automatic flush_expr();
        char_req_t r;
        int        i;
        for (i = 0; i < expr_buf.size(); i++)
        begin
            r.sym   = expr_buf[i];
            r.fin   = (i == expr_buf.size() - 1);
            r.drain = (i == 0) && !drain_marked && char_q.size() >= DRAIN_AT;
            if (r.drain)
                drain_marked = 1'b1;
            char_q.insert(char_q.size(), r);
        end
        expr_buf.delete();
    endtask

    // ------------------------------------------------------------------
    // idling, hold-off and checking
    // ------------------------------------------------------------------

    // percent of cycles a side idles: sender light / sink heavy, then swapped, then none
    function automatic int idle_pct(input bit sink_side);
        if (sent_count < total_items / 3)
            return sink_side ? 63 : 6;
        if (sent_count < 2 * total_items / 3)
            return sink_side ? 6 : 63;
        return 0;
    endfunction

    task automatic report(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_token();
        token_t want;
        if (pending_tokens.size() == 0)
        begin
            report($sformatf("token %0d arrived with nothing expected (kind %0d)",
                             token_count, token_kind));
            return;
        end
        want = pending_tokens.pop_front();
        if (token_kind !== want.kind)
            report($sformatf("token %0d token_kind %0d, expected %0d",
                             token_count, token_kind, want.kind));
        if (operand_char !== want.ch)
            report($sformatf("token %0d operand_char %h, expected %h",
                             token_count, operand_char, want.ch));
        if (op_code !== want.op)
            report($sformatf("token %0d op_code %0d, expected %0d",
                             token_count, op_code, want.op));
        if (token_end !== want.tend)
            report($sformatf("token %0d token_end %b, expected %b",
                             token_count, token_end, want.tend));
        if (error !== want.err)
            report($sformatf("token %0d error %0d, expected %0d",
                             token_count, error, want.err));
        if (done_res !== want.done)
            report($sformatf("token %0d done_res %b, expected %b",
                             token_count, done_res, want.done));
        token_count++;
    endtask

    // driver: predicts on every accepted request, then offers the next character
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_symbol(symbol, last);
                sent_count <= sent_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (char_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0) &&
                    !(char_q[0].drain && pending_tokens.size() != 0))
                begin
                    in_valid <= 1'b1;
                    symbol   <= char_q[0].sym;
                    last     <= char_q[0].fin;
                    void'(char_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long sink hold-off while the sender keeps going, to back up the block
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && sent_count >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // monitor: checks each accepted token against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_token();
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL infix_to_postfix_converter_core");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        int stop_at;
        // single operand, lone close, open left at the end
        add_text("x");
        flush_expr();
        add_text(")");
        flush_expr();
        add_text("(a");
        flush_expr();
        // all four operators with their precedence
        add_text("a+b*c^d-e");
        flush_expr();
        // function name before a parenthesized operand, then one as the final characters
        add_text("cos(t)");
        flush_expr();
        add_text("tan");
        flush_expr();
        // character code extremes
        add_char(8'hFF);
        flush_expr();
        add_char(8'h00);
        flush_expr();

        stop_at = char_q.size() + RANDOM_CHARS;
        build_overflow();
        flush_expr();
        while (char_q.size() < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                build_formula();
            else if (pick < 85)
                build_broken();
            else
                build_noise();
            flush_expr();
        end
        total_items = char_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (char_q.size() != 0 || in_valid || pending_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS infix_to_postfix_converter_core");
        else
            $display("FAIL infix_to_postfix_converter_core");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/itp_pkg.sv
rtl/itp_datapath.sv
rtl/itp_controller.sv
rtl/infix_to_postfix_converter_core.sv
dv/testbench.sv
